// ===== design/fbpa_pkg.sv =====
// Shared command, status and register codes plus free-list handshake types.
`default_nettype none
package fbpa_pkg;

  // Command codes carried on the cmd field.
  localparam logic [1:0] CMD_ALLOC_REQ = 2'd0;
  localparam logic [1:0] CMD_ALLOC_BUF = 2'd1;
  localparam logic [1:0] CMD_FREE_REQ  = 2'd2;
  localparam logic [1:0] CMD_FREE_BUF  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_GRANTED  = 2'd0;
  localparam logic [1:0] ST_HEAP     = 2'd1;
  localparam logic [1:0] ST_RETURNED = 2'd2;
  localparam logic [1:0] ST_NOT_POOL = 2'd3;

  // Pool identifiers.
  localparam logic [1:0] POOL_REQUEST = 2'd0;
  localparam logic [1:0] POOL_SMALL   = 2'd1;
  localparam logic [1:0] POOL_LARGE   = 2'd2;
  localparam logic [1:0] POOL_NONE    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_REQUEST_BASE = 2'd0;
  localparam logic [1:0] REG_SMALL_BASE   = 2'd1;
  localparam logic [1:0] REG_LARGE_BASE   = 2'd2;

  // Reset values of the base registers.
  localparam logic [31:0] RST_REQUEST_BASE = 32'h0000_0000;
  localparam logic [31:0] RST_SMALL_BASE   = 32'h0001_0000;
  localparam logic [31:0] RST_LARGE_BASE   = 32'h0002_0000;

  // Operation request into one free list.
  typedef struct packed {
    logic pop;
    logic push;
  } fl_ctrl_t;

  // Condition reported by one free list.
  typedef struct packed {
    logic empty;
    logic clearing;
  } fl_stat_t;

endpackage
`default_nettype wire

// ===== design/fbpa_addr_decode.sv =====
// Range test and block index extraction of a freed address for one pool.
`default_nettype none
module fbpa_addr_decode #(
  parameter int COUNT = 64,
  parameter int BYTES = 128
) (
  input  logic [31:0]                base,
  input  logic [31:0]                addr,
  output logic                       hit,
  output logic [$clog2(COUNT)-1:0]   idx
);
  localparam int IW = $clog2(COUNT);
  localparam logic [33:0] SPAN = 34'(COUNT * BYTES);
  localparam logic [31:0] Bytes32 = 32'(BYTES);

  logic [33:0] limit;
  logic [31:0] offset;
  logic [31:0] quotient;

  // The upper bound is formed without wrap, so a range past 4 GiB is cut off there.
  assign limit    = {2'b00, base} + SPAN;
  assign hit      = (addr >= base) && ({2'b00, addr} < limit);
  assign offset   = addr - base;
  assign quotient = offset / Bytes32;
  assign idx      = quotient[IW-1:0];

endmodule
`default_nettype wire

// ===== design/fbpa_free_list.sv =====
// LIFO free list of one pool: head register, cached link and next-index memory.
`default_nettype none
module fbpa_free_list #(
  parameter int COUNT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fbpa_pkg::fl_ctrl_t            ctrl,
  input  logic [$clog2(COUNT)-1:0]      push_idx,
  output logic [$clog2(COUNT+1)-1:0]    head,
  output fbpa_pkg::fl_stat_t            stat
);
  import fbpa_pkg::*;

  localparam int IW = $clog2(COUNT);
  localparam int VW = $clog2(COUNT + 1);
  localparam logic [VW-1:0] NULL_IDX = VW'(COUNT);
  localparam logic [IW-1:0] LAST_IDX = IW'(COUNT - 1);

  logic [VW-1:0] mem [COUNT];
  logic [VW-1:0] rd_data;
  logic [VW-1:0] link_reg;
  logic          link_from_mem;
  logic [VW-1:0] link;
  logic          clearing;
  logic [IW-1:0] clr_ptr;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [VW-1:0] wr_data;
  logic          rd_en;

  // The link is the successor of the head; after a pop it arrives from the memory.
  assign link = link_from_mem ? rd_data : link_reg;

  // Memory port selection: the clearing pass owns the write port after reset.
  assign wr_en   = clearing || ctrl.push;
  assign wr_addr = clearing ? clr_ptr : push_idx;
  assign wr_data = clearing ? (VW'(clr_ptr) + VW'(1)) : head;
  assign rd_en   = ctrl.pop && (link != NULL_IDX);

  // Next-index memory with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[link[IW-1:0]];
    end
  end

  // Head, link and clearing-pass control.
  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      link_reg      <= VW'(1);
      link_from_mem <= 1'b0;
      clearing      <= 1'b1;
      clr_ptr       <= '0;
    end else begin
      if (clearing) begin
        clr_ptr <= clr_ptr + IW'(1);
        if (clr_ptr == LAST_IDX) begin
          clearing <= 1'b0;
        end
      end
      if (ctrl.pop) begin
        head <= link;
        if (link == NULL_IDX) begin
          link_reg      <= NULL_IDX;
          link_from_mem <= 1'b0;
        end else begin
          link_from_mem <= 1'b1;
        end
      end else if (ctrl.push) begin
        head          <= VW'(push_idx);
        link_reg      <= head;
        link_from_mem <= 1'b0;
      end
    end
  end

  assign stat.empty    = (head == NULL_IDX);
  assign stat.clearing = clearing;

`ifndef SYNTH
  // A pop and a push never arrive in the same cycle.
  a_single_op: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.pop && ctrl.push))
    else $error("free list got pop and push together");

  // An empty list is never popped.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> (head != NULL_IDX))
    else $error("pop from empty free list");

  // No operation reaches the list while the clearing pass runs.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(ctrl.pop || ctrl.push))
    else $error("free list operation during clearing pass");

  // The head never points past the null index.
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= NULL_IDX)
    else $error("free list head out of range");
`endif

endmodule
`default_nettype wire

// ===== design/fixed_block_pool_allocator_core.sv =====
// Top level of the fixed-block pool allocator: input stage, pool update and result stage.
// An accepted word waits in the input register until its result enters the result register.
// Throughput: one word per cycle while out_ready is high and no clearing pass runs.
// Reset: synchronous; base registers take their defaults and heads return to block 0.
// After reset, each next-index memory is rewritten by a clearing pass; in_ready stays low
// until every pass has ended.
`default_nettype none
module fixed_block_pool_allocator_core #(
  parameter int REQUEST_BLOCKS      = 64,
  parameter int SMALL_BLOCKS        = 8,
  parameter int LARGE_BLOCKS        = 2,
  parameter int REQUEST_BLOCK_BYTES = 128,
  parameter int SMALL_BLOCK_BYTES   = 4096,
  parameter int LARGE_BLOCK_BYTES   = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] byte_count,
  input  logic [31:0] block_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [1:0]  pool_id,
  output logic [31:0] granted_address
);
  import fbpa_pkg::*;

  localparam int RIW = $clog2(REQUEST_BLOCKS);
  localparam int SIW = $clog2(SMALL_BLOCKS);
  localparam int LIW = $clog2(LARGE_BLOCKS);
  localparam int RVW = $clog2(REQUEST_BLOCKS + 1);
  localparam int SVW = $clog2(SMALL_BLOCKS + 1);
  localparam int LVW = $clog2(LARGE_BLOCKS + 1);
  localparam logic [31:0] ReqBytes   = 32'(REQUEST_BLOCK_BYTES);
  localparam logic [31:0] SmallBytes = 32'(SMALL_BLOCK_BYTES);
  localparam logic [31:0] LargeBytes = 32'(LARGE_BLOCK_BYTES);

  // Base registers.
  logic [31:0] request_pool_base;
  logic [31:0] small_pool_base;
  logic [31:0] large_pool_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      request_pool_base <= RST_REQUEST_BASE;
      small_pool_base   <= RST_SMALL_BASE;
      large_pool_base   <= RST_LARGE_BASE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REQUEST_BASE: request_pool_base <= cfg_data;
        REG_SMALL_BASE:   small_pool_base   <= cfg_data;
        REG_LARGE_BASE:   large_pool_base   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Address decode of the incoming word, done before the input register.
  logic           req_hit_d, small_hit_d, large_hit_d;
  logic [RIW-1:0] req_idx_d;
  logic [SIW-1:0] small_idx_d;
  logic [LIW-1:0] large_idx_d;

  fbpa_addr_decode #(.COUNT(REQUEST_BLOCKS), .BYTES(REQUEST_BLOCK_BYTES)) u_req_dec (
    .base(request_pool_base), .addr(block_address), .hit(req_hit_d), .idx(req_idx_d)
  );
  fbpa_addr_decode #(.COUNT(SMALL_BLOCKS), .BYTES(SMALL_BLOCK_BYTES)) u_small_dec (
    .base(small_pool_base), .addr(block_address), .hit(small_hit_d), .idx(small_idx_d)
  );
  fbpa_addr_decode #(.COUNT(LARGE_BLOCKS), .BYTES(LARGE_BLOCK_BYTES)) u_large_dec (
    .base(large_pool_base), .addr(block_address), .hit(large_hit_d), .idx(large_idx_d)
  );

  // Input register.
  logic           s1_valid;
  logic [1:0]     s1_cmd;
  logic           s1_req_fit, s1_small_fit, s1_large_fit;
  logic           s1_req_hit, s1_small_hit, s1_large_hit;
  logic [RIW-1:0] s1_req_idx;
  logic [SIW-1:0] s1_small_idx;
  logic [LIW-1:0] s1_large_idx;

  logic out_load;
  logic busy;

  fl_stat_t req_stat, small_stat, large_stat;

  assign busy     = req_stat.clearing || small_stat.clearing || large_stat.clearing;
  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !busy && (!s1_valid || out_load);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd       <= cmd;
      s1_req_fit   <= (byte_count <= ReqBytes);
      s1_small_fit <= (byte_count <= SmallBytes);
      s1_large_fit <= (byte_count == LargeBytes);
      s1_req_hit   <= req_hit_d;
      s1_small_hit <= small_hit_d;
      s1_large_hit <= large_hit_d;
      s1_req_idx   <= req_idx_d;
      s1_small_idx <= small_idx_d;
      s1_large_idx <= large_idx_d;
    end
  end

  // Free lists.
  fl_ctrl_t       req_ctrl, small_ctrl, large_ctrl;
  logic [RVW-1:0] req_head;
  logic [SVW-1:0] small_head;
  logic [LVW-1:0] large_head;

  fbpa_free_list #(.COUNT(REQUEST_BLOCKS)) u_req_list (
    .clk(clk), .rst(rst), .ctrl(req_ctrl), .push_idx(s1_req_idx),
    .head(req_head), .stat(req_stat)
  );
  fbpa_free_list #(.COUNT(SMALL_BLOCKS)) u_small_list (
    .clk(clk), .rst(rst), .ctrl(small_ctrl), .push_idx(s1_small_idx),
    .head(small_head), .stat(small_stat)
  );
  fbpa_free_list #(.COUNT(LARGE_BLOCKS)) u_large_list (
    .clk(clk), .rst(rst), .ctrl(large_ctrl), .push_idx(s1_large_idx),
    .head(large_head), .stat(large_stat)
  );

  // Block addresses of the current heads, wrapping at 4 GiB.
  logic [31:0] req_addr, small_addr, large_addr;

  assign req_addr   = request_pool_base + 32'(req_head[RIW-1:0]) * ReqBytes;
  assign small_addr = small_pool_base + 32'(small_head[SIW-1:0]) * SmallBytes;
  assign large_addr = large_pool_base + 32'(large_head[LIW-1:0]) * LargeBytes;

  // Pool selection and result formation.
  logic [1:0]  status_next;
  logic [1:0]  pool_id_next;
  logic [31:0] granted_address_next;

  always_comb begin
    req_ctrl             = '0;
    small_ctrl           = '0;
    large_ctrl           = '0;
    status_next          = ST_HEAP;
    pool_id_next         = POOL_NONE;
    granted_address_next = '0;
    unique case (s1_cmd)
      CMD_ALLOC_REQ: begin
        if (s1_req_fit && !req_stat.empty) begin
          req_ctrl.pop         = out_load;
          status_next          = ST_GRANTED;
          pool_id_next         = POOL_REQUEST;
          granted_address_next = req_addr;
        end
      end
      CMD_ALLOC_BUF: begin
        if (s1_small_fit && !small_stat.empty) begin
          small_ctrl.pop       = out_load;
          status_next          = ST_GRANTED;
          pool_id_next         = POOL_SMALL;
          granted_address_next = small_addr;
        end else if (s1_large_fit && !large_stat.empty) begin
          large_ctrl.pop       = out_load;
          status_next          = ST_GRANTED;
          pool_id_next         = POOL_LARGE;
          granted_address_next = large_addr;
        end
      end
      CMD_FREE_REQ: begin
        status_next = ST_NOT_POOL;
        if (s1_req_hit) begin
          req_ctrl.push = out_load;
          status_next   = ST_RETURNED;
          pool_id_next  = POOL_REQUEST;
        end
      end
      CMD_FREE_BUF: begin
        status_next = ST_NOT_POOL;
        if (s1_small_hit) begin
          small_ctrl.push = out_load;
          status_next     = ST_RETURNED;
          pool_id_next    = POOL_SMALL;
        end else if (s1_large_hit) begin
          large_ctrl.push = out_load;
          status_next     = ST_RETURNED;
          pool_id_next    = POOL_LARGE;
        end
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status          <= status_next;
      pool_id         <= pool_id_next;
      granted_address <= granted_address_next;
    end
  end

`ifndef SYNTH
  // No word is taken while the free lists are being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready)
    else $error("input accepted during clearing pass");

  // Only a grant carries a nonzero address.
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_GRANTED)) |-> (granted_address == 32'd0))
    else $error("nonzero address on a result that is not a grant");

  // Heap fallback and not-pool results name no pool.
  a_pool_none: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((status == ST_HEAP) || (status == ST_NOT_POOL)))
      |-> (pool_id == POOL_NONE))
    else $error("pool named on a fallback or not-pool result");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_fixed_block_pool_allocator_core.sv =====
// Self-checking testbench for the fixed-block pool allocator core.
`timescale 1ns / 100ps

module tb_fixed_block_pool_allocator_core;
  import fbpa_pkg::*;

  localparam int REQ_BLOCKS   = 64;
  localparam int SMALL_BLOCKS = 8;
  localparam int LARGE_BLOCKS = 2;
  localparam int REQ_BYTES    = 128;
  localparam int SMALL_BYTES  = 4096;
  localparam int LARGE_BYTES  = 65536;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] nbytes;
    logic [31:0] addr;
  } word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  pool;
    logic [31:0] addr;
  } result_t;

  typedef struct packed {
    word_t   w;
    logic    typed;
    result_t r;
  } row_t;

  typedef struct packed {
    logic [1:0] pool;
    logic [6:0] idx;
  } block_ref_t;

  logic        clk;
  logic        rst           = 1'b1;
  logic        cfg_we        = 1'b0;
  logic [1:0]  cfg_index     = REG_REQUEST_BASE;
  logic [31:0] cfg_data      = 32'd0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd           = CMD_ALLOC_REQ;
  logic [31:0] byte_count    = 32'd0;
  logic [31:0] block_address = 32'd0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [1:0]  status;
  logic [1:0]  pool_id;
  logic [31:0] granted_address;

  // Free-list state mirrored per pool, indexed by pool identifier.
  logic [6:0]  pool_link [3][64];
  logic [6:0]  pool_head [3];
  logic [31:0] pool_base [3];

  result_t     pending_results [$];
  block_ref_t  live_blocks [$];
  row_t        directed_rows [$];
  int          mismatches    = 0;
  int          results_seen  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  fixed_block_pool_allocator_core #(
    .REQUEST_BLOCKS      (REQ_BLOCKS),
    .SMALL_BLOCKS        (SMALL_BLOCKS),
    .LARGE_BLOCKS        (LARGE_BLOCKS),
    .REQUEST_BLOCK_BYTES (REQ_BYTES),
    .SMALL_BLOCK_BYTES   (SMALL_BYTES),
    .LARGE_BLOCK_BYTES   (LARGE_BYTES)
  ) DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .byte_count      (byte_count),
    .block_address   (block_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .pool_id         (pool_id),
    .granted_address (granted_address)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] pool_bytes(input logic [1:0] p);
    case (p)
      POOL_REQUEST: return REQ_BYTES;
      POOL_SMALL:   return SMALL_BYTES;
      default:      return LARGE_BYTES;
    endcase
  endfunction

  function automatic logic [6:0] pool_blocks(input logic [1:0] p);
    case (p)
      POOL_REQUEST: return 7'(REQ_BLOCKS);
      POOL_SMALL:   return 7'(SMALL_BLOCKS);
      default:      return 7'(LARGE_BLOCKS);
    endcase
  endfunction

  // Every pool starts as a chain 0, 1, 2, ... ending in the null index.
  task automatic reset_pools();
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < 64; i++) pool_link[p][i] = 7'(i + 1);
      pool_head[p] = 7'd0;
    end
    pool_base[POOL_REQUEST] = RST_REQUEST_BASE;
    pool_base[POOL_SMALL]   = RST_SMALL_BASE;
    pool_base[POOL_LARGE]   = RST_LARGE_BASE;
  endtask

  // Take the head block of a pool; fails when the list is empty.
  function automatic bit pop_block(input logic [1:0] p, output logic [6:0] idx);
    logic [6:0] h;
    h = pool_head[p];
    if (h >= pool_blocks(p)) return 1'b0;
    idx = h;
    pool_head[p] = (pool_link[p][h] > pool_blocks(p)) ? pool_blocks(p) : pool_link[p][h];
    return 1'b1;
  endfunction

  // Push the block holding the address; the range is checked without wrap.
  function automatic bit push_block(input logic [1:0] p, input logic [31:0] a);
    logic [63:0] lo, hi, at, slot;
    lo = 64'(pool_base[p]);
    at = 64'(a);
    hi = 64'(pool_blocks(p));
    hi = lo + hi * 64'(pool_bytes(p));
    if (at < lo || at >= hi) return 1'b0;
    slot = (at - lo) / 64'(pool_bytes(p));
    pool_link[p][slot[6:0]] = pool_head[p];
    pool_head[p] = slot[6:0];
    return 1'b1;
  endfunction

  // Work out the result of one word and advance the mirrored free lists.
  function automatic result_t predict_result(input word_t w);
    result_t    r;
    logic [6:0] idx;
    logic [1:0] hit;
    r.status = ST_HEAP;
    r.pool   = POOL_NONE;
    r.addr   = 32'd0;
    hit      = POOL_NONE;
    case (w.op)
      CMD_ALLOC_REQ: begin
        if (w.nbytes <= REQ_BYTES) begin
          if (pop_block(POOL_REQUEST, idx)) hit = POOL_REQUEST;
        end
      end
      CMD_ALLOC_BUF: begin
        if (w.nbytes <= SMALL_BYTES) begin
          if (pop_block(POOL_SMALL, idx)) hit = POOL_SMALL;
        end
        if (hit == POOL_NONE && w.nbytes == LARGE_BYTES) begin
          if (pop_block(POOL_LARGE, idx)) hit = POOL_LARGE;
        end
      end
      CMD_FREE_REQ: begin
        r.status = ST_NOT_POOL;
        if (push_block(POOL_REQUEST, w.addr)) begin
          r.status = ST_RETURNED;
          r.pool   = POOL_REQUEST;
        end
      end
      CMD_FREE_BUF: begin
        r.status = ST_NOT_POOL;
        if (push_block(POOL_SMALL, w.addr)) begin
          r.status = ST_RETURNED;
          r.pool   = POOL_SMALL;
        end else if (push_block(POOL_LARGE, w.addr)) begin
          r.status = ST_RETURNED;
          r.pool   = POOL_LARGE;
        end
      end
    endcase
    if (hit != POOL_NONE) begin
      r.status = ST_GRANTED;
      r.pool   = hit;
      r.addr   = pool_base[hit] + {25'd0, idx} * pool_bytes(hit);
    end
    return r;
  endfunction

  // Sizes that sit on or next to the pool limits, or anywhere at all.
  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return REQ_BYTES;
      2:       return REQ_BYTES + 1;
      3:       return SMALL_BYTES;
      4:       return SMALL_BYTES + 1;
      5:       return LARGE_BYTES;
      6:       return ($urandom_range(0, 1) != 0) ? LARGE_BYTES - 1 : LARGE_BYTES + 1;
      default: return $urandom;
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h at %0t", what, want, seen, $time);
  endtask

  task automatic add_row(input logic [1:0] op, input logic [31:0] nbytes,
                         input logic [31:0] addr, input int typed,
                         input logic [1:0] st, input logic [1:0] pool,
                         input logic [31:0] gaddr);
    row_t row;
    row.w.op     = op;
    row.w.nbytes = nbytes;
    row.w.addr   = addr;
    row.typed    = (typed != 0);
    row.r.status = st;
    row.r.pool   = pool;
    row.r.addr   = gaddr;
    directed_rows.push_back(row);
  endtask

  // Offer one word, possibly after an idle burst, and book its result once taken.
  task automatic send_word(input word_t w, input logic typed, input result_t typed_r,
                           output result_t got);
    int         gap;
    block_ref_t blk;
    logic [31:0] span;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    cmd           <= w.op;
    byte_count    <= w.nbytes;
    block_address <= w.addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = predict_result(w);
    pending_results.push_back(typed ? typed_r : got);
    if (got.status == ST_GRANTED) begin
      span     = got.addr - pool_base[got.pool];
      blk.pool = got.pool;
      blk.idx  = 7'(span / pool_bytes(got.pool));
      live_blocks.push_back(blk);
    end
  endtask

  // Stop offering and wait until every booked result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_bases(input logic [31:0] req_base, input logic [31:0] sml_base,
                           input logic [31:0] lrg_base);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_REQUEST_BASE;
    cfg_data  <= req_base;
    @(negedge clk);
    cfg_index <= REG_SMALL_BASE;
    cfg_data  <= sml_base;
    @(negedge clk);
    cfg_index <= REG_LARGE_BASE;
    cfg_data  <= lrg_base;
    @(negedge clk);
    cfg_we    <= 1'b0;
    pool_base[POOL_REQUEST] = req_base;
    pool_base[POOL_SMALL]   = sml_base;
    pool_base[POOL_LARGE]   = lrg_base;
  endtask

  // One setting of the bases followed by random traffic. Most words either
  // allocate or free a block handed out earlier; the rest is noise.
  task automatic run_phase(input int count, input logic [31:0] req_base,
                           input logic [31:0] sml_base, input logic [31:0] lrg_base,
                           input int unsigned s_pct, input int unsigned r_pct);
    word_t      w;
    result_t    got;
    result_t    none;
    block_ref_t blk;
    logic [31:0] ofs;
    logic [1:0] p;
    int         k;
    int         pick;
    bit         from_live;
    none = '0;
    drain_results();
    set_bases(req_base, sml_base, lrg_base);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int n = 0; n < count; n++) begin
      from_live = 1'b0;
      k         = 0;
      pick      = $urandom_range(0, 99);
      if (pick < 10) begin
        // Noise: any command, sizes and addresses around the pool edges.
        w.op     = 2'($urandom_range(0, 3));
        w.nbytes = pick_size();
        p        = 2'($urandom_range(0, 2));
        case ($urandom_range(0, 5))
          0:       w.addr = pool_base[p] - 1;
          1:       w.addr = pool_base[p];
          2:       w.addr = pool_base[p] + pool_blocks(p) * pool_bytes(p) - 1;
          3:       w.addr = pool_base[p] + pool_blocks(p) * pool_bytes(p);
          4:       w.addr = 32'hFFFF_FFFF;
          default: w.addr = $urandom;
        endcase
      end else if (live_blocks.size() == 0 || (pick < 55 && live_blocks.size() < 40)) begin
        w.addr = $urandom;
        if ($urandom_range(0, 1) != 0) begin
          w.op     = CMD_ALLOC_REQ;
          w.nbytes = ($urandom_range(0, 4) != 0) ? $urandom_range(0, REQ_BYTES) : pick_size();
        end else begin
          w.op = CMD_ALLOC_BUF;
          case ($urandom_range(0, 7))
            0, 1:    w.nbytes = LARGE_BYTES;
            2:       w.nbytes = pick_size();
            default: w.nbytes = $urandom_range(0, SMALL_BYTES);
          endcase
        end
      end else begin
        // Free a held block, sometimes through the wrong command.
        from_live = 1'b1;
        k         = $urandom_range(0, live_blocks.size() - 1);
        blk       = live_blocks[k];
        w.op      = (blk.pool == POOL_REQUEST) ? CMD_FREE_REQ : CMD_FREE_BUF;
        if ($urandom_range(0, 19) == 0)
          w.op = (w.op == CMD_FREE_REQ) ? CMD_FREE_BUF : CMD_FREE_REQ;
        ofs      = ($urandom_range(0, 1) == 0) ? 32'd0
                                              : $urandom_range(0, pool_bytes(blk.pool) - 1);
        w.addr   = pool_base[blk.pool] + {25'd0, blk.idx} * pool_bytes(blk.pool) + ofs;
        w.nbytes = $urandom;
      end
      send_word(w, 1'b0, none, got);
      // A block that went back stays on the list now and then, for double frees.
      if (from_live && got.status == ST_RETURNED && $urandom_range(0, 9) != 0)
        live_blocks.delete(k);
    end
  endtask

  // Compare every accepted result word with the oldest booked result.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch("word with nothing pending", 32'd0, granted_address);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          note_mismatch("status", 32'(want.status), 32'(status));
        if (pool_id !== want.pool)
          note_mismatch("pool_id", 32'(want.pool), 32'(pool_id));
        if (granted_address !== want.addr)
          note_mismatch("granted_address", want.addr, granted_address);
      end
    end
  end

  // Result side: random stalls, plus two long hold-offs that back the block up.
  initial begin : result_sink
    int hold;
    int long_stalls;
    hold        = 0;
    long_stalls = 0;
    forever begin
      @(negedge clk);
      if ((long_stalls == 0 && results_seen >= 300) ||
          (long_stalls == 1 && results_seen >= 750)) begin
        long_stalls++;
        hold = 40;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        out_ready <= 1'b0;
        hold = $urandom_range(0, 4);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    result_t got;
    reset_pools();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 20;

    // Directed words at the reset bases: size limits, pool exhaustion,
    // range edges, a free inside a block, and a block freed twice.
    add_row(CMD_ALLOC_REQ, 32'd0,          32'hFFFF_FFFF, 1, ST_GRANTED,  POOL_REQUEST, 32'h0);
    add_row(CMD_ALLOC_REQ, 32'd128,        32'h0,         1, ST_GRANTED,  POOL_REQUEST, 32'h80);
    add_row(CMD_ALLOC_REQ, 32'd129,        32'h0,         1, ST_HEAP,     POOL_NONE,    32'h0);
    add_row(CMD_ALLOC_REQ, 32'hFFFF_FFFF,  32'h0,         1, ST_HEAP,     POOL_NONE,    32'h0);
    add_row(CMD_ALLOC_BUF, 32'd0,          32'h0,         1, ST_GRANTED,  POOL_SMALL,
            32'h0001_0000);
    add_row(CMD_ALLOC_BUF, 32'd4096,       32'h0,         1, ST_GRANTED,  POOL_SMALL,
            32'h0001_1000);
    add_row(CMD_ALLOC_BUF, 32'd4097,       32'h0,         1, ST_HEAP,     POOL_NONE,    32'h0);
    add_row(CMD_ALLOC_BUF, 32'd65535,      32'h0,         1, ST_HEAP,     POOL_NONE,    32'h0);
    add_row(CMD_ALLOC_BUF, 32'd65536,      32'h0,         1, ST_GRANTED,  POOL_LARGE,
            32'h0002_0000);
    add_row(CMD_ALLOC_BUF, 32'd65536,      32'h0,         1, ST_GRANTED,  POOL_LARGE,
            32'h0003_0000);
    add_row(CMD_ALLOC_BUF, 32'd65536,      32'h0,         1, ST_HEAP,     POOL_NONE,    32'h0);
    add_row(CMD_ALLOC_BUF, 32'd65537,      32'h0,         1, ST_HEAP,     POOL_NONE,    32'h0);
    add_row(CMD_FREE_REQ,  32'hFFFF_FFFF,  32'h80,        1, ST_RETURNED, POOL_REQUEST, 32'h0);
    add_row(CMD_FREE_REQ,  32'h0,          32'h7F,        1, ST_RETURNED, POOL_REQUEST, 32'h0);
    add_row(CMD_ALLOC_REQ, 32'd1,          32'h0,         0, ST_HEAP,     POOL_NONE,    32'h0);
    add_row(CMD_FREE_REQ,  32'h0,          32'h2000,      1, ST_NOT_POOL, POOL_NONE,    32'h0);
    add_row(CMD_FREE_REQ,  32'h0,          32'h1FFF,      1, ST_RETURNED, POOL_REQUEST, 32'h0);
    add_row(CMD_FREE_REQ,  32'h0,          32'h1F80,      1, ST_RETURNED, POOL_REQUEST, 32'h0);
    add_row(CMD_ALLOC_REQ, 32'd64,         32'h0,         0, ST_HEAP,     POOL_NONE,    32'h0);
    add_row(CMD_ALLOC_REQ, 32'd64,         32'h0,         0, ST_HEAP,     POOL_NONE,    32'h0);
    add_row(CMD_FREE_BUF,  32'h0,          32'h0001_7FFF, 1, ST_RETURNED, POOL_SMALL,   32'h0);
    add_row(CMD_FREE_BUF,  32'h0,          32'h0001_8000, 1, ST_NOT_POOL, POOL_NONE,    32'h0);
    add_row(CMD_FREE_BUF,  32'h0,          32'h0003_FFFF, 1, ST_RETURNED, POOL_LARGE,   32'h0);
    add_row(CMD_FREE_BUF,  32'h0,          32'h0004_0000, 1, ST_NOT_POOL, POOL_NONE,    32'h0);
    add_row(CMD_FREE_BUF,  32'h0,          32'h0002_0000, 1, ST_RETURNED, POOL_LARGE,   32'h0);
    add_row(CMD_FREE_REQ,  32'h0,          32'h0001_0000, 1, ST_NOT_POOL, POOL_NONE,    32'h0);
    foreach (directed_rows[i])
      send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].r, got);

    // Random phases over a range of base settings; the last one runs flat out.
    run_phase(260, $urandom & 32'hFFFF_FF80, $urandom & 32'hFFFF_F000,
              $urandom & 32'hFFFF_0000, 30, 30);
    run_phase(150, 32'h0, 32'h0, 32'h0, 0, 40);
    run_phase(60, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40, 0);
    run_phase(150, 32'hFFFF_F000, 32'hFFFF_8000, 32'hFFFF_0000, 20, 20);
    begin : overlap_bases
      logic [31:0] shared;
      shared = $urandom & 32'hFFFF_F000;
      run_phase(200, shared, shared, shared, 50, 50);
    end
    run_phase(200, $urandom, $urandom, $urandom, 10, 30);
    run_phase(230, RST_REQUEST_BASE, RST_SMALL_BASE, RST_LARGE_BASE, 0, 0);

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
